// File: hdl/mcts_pkg.sv
// shared types and constants for the minimum-cost tour search
package mcts_pkg;

  // cost store geometry
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = 8;

  // fixed field widths
  localparam int EDGE_IN_W = 20;
  localparam int TOUR_W    = 24;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0]  CITY_COUNT_RESET = 5'd4;
  localparam logic [TOUR_W-1:0] TOUR_MAX         = 24'hFFFFFF;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // write one matrix beat into the store
    logic init;      // clear best cost and start city for a new search
    logic start;     // set up the search from the current start city
    logic step;      // examine the top of the path stack, issue a store read
    logic close;     // evaluate the closing edge back to the start city
    logic try_edge;  // evaluate a candidate next city
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic skip_start;  // a zero-cost tour is known, nothing can beat it
    logic close_now;   // path holds every city, the closing edge is next
    logic exhausted;   // all candidates of the top level have been tried
    logic at_root;     // path stack holds only the start city
    logic last_start;  // current start city is the last one
  } stat_t;

endpackage

// File: hdl/min_cost_tour_search.sv
// top level: exhaustive minimum-cost tour search with apb configuration
// matrix beats are taken one per cycle while idle; busy rises after the last beat.
// the search steps through each start city, pop, candidate city tried and closing edge;
// its worst case grows with the factorial of city_count.
// the result strobe comes on the cycle busy falls; it cannot be stalled.
// reset: city_count 4, load position and control state cleared; no clearing pass.
module min_cost_tour_search #(
  parameter int MAX_CITIES = 16,
  parameter int COST_BITS  = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [mcts_pkg::EDGE_IN_W-1:0]  edge_cost_i,
  input  logic                            matrix_last_i,
  // result channel
  output logic                            done_o,
  output logic [mcts_pkg::TOUR_W-1:0]     tour_cost_o,
  output logic                            tour_found_o,
  // apb configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int EDGE_W = (COST_BITS < mcts_pkg::EDGE_IN_W) ? COST_BITS
                                                             : mcts_pkg::EDGE_IN_W;
  localparam logic REG_CITY_COUNT = 1'b0;

  logic [mcts_pkg::CFG_W-1:0] city_count_q;
  mcts_pkg::cmd_t             cmd;
  mcts_pkg::stat_t            stat;
  logic                       cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CITY_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= mcts_pkg::CITY_COUNT_RESET;
    end else if (cfg_wr) begin
      city_count_q <= pwdata[mcts_pkg::CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CITY_COUNT) ? 32'(city_count_q) : '0;

  // controller
  mcts_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .matrix_last_i (matrix_last_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .busy_o        (busy),
    .done_o        (done_o)
  );

  // datapath
  mcts_dp #(
    .MAX_CITIES (MAX_CITIES),
    .EDGE_W     (EDGE_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .city_count_i  (city_count_q),
    .edge_cost_i   (edge_cost_i),
    .matrix_last_i (matrix_last_i),
    .tour_cost_o   (tour_cost_o),
    .tour_found_o  (tour_found_o)
  );

`ifndef SYNTHESIS
  // a result beat never overlaps a running search
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // the final matrix beat always launches a search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && matrix_last_i) |=> busy)
    else $error("search did not start after last beat");

  // every search ends with exactly one result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> done_o)
    else $error("search ended without a result");

  // a missing tour reports zero cost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !tour_found_o) |-> (tour_cost_o == '0))
    else $error("nonzero cost without a tour");
`endif

endmodule

// File: hdl/mcts_ram.sv
// generic simple dual-port ram with registered read
module mcts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/mcts_ctrl.sv
// sequencer for matrix loading and the depth-first tour search
module mcts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           matrix_last_i,
  input  mcts_pkg::stat_t stat_i,
  output mcts_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_STEP,
    ST_CLOSE,
    ST_TRY
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (matrix_last_i) begin
            cmd_o.init = 1'b1;
            state_d    = ST_START;
          end
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        if (stat_i.skip_start) begin
          if (stat_i.last_start) begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        if (stat_i.close_now) begin
          state_d = ST_CLOSE;
        end else if (stat_i.exhausted) begin
          if (stat_i.at_root) begin
            if (stat_i.last_start) begin
              state_d = ST_IDLE;
              done_d  = 1'b1;
            end else begin
              state_d = ST_START;
            end
          end
        end else begin
          state_d = ST_TRY;
        end
      end
      ST_CLOSE: begin
        cmd_o.close = 1'b1;
        if (stat_i.at_root) begin
          if (stat_i.last_start) begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end else begin
            state_d = ST_START;
          end
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_TRY: begin
        cmd_o.try_edge = 1'b1;
        state_d        = ST_STEP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// File: hdl/mcts_dp.sv
// datapath: cost store, path stacks, visited mask and best-cost tracking
module mcts_dp #(
  parameter int MAX_CITIES = 16,
  parameter int EDGE_W     = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcts_pkg::cmd_t                cmd_i,
  output mcts_pkg::stat_t               stat_o,
  input  logic [mcts_pkg::CFG_W-1:0]    city_count_i,
  input  logic [mcts_pkg::EDGE_IN_W-1:0] edge_cost_i,
  input  logic                          matrix_last_i,
  output logic [mcts_pkg::TOUR_W-1:0]   tour_cost_o,
  output logic                          tour_found_o
);

  localparam int CITY_W = $clog2(MAX_CITIES);
  localparam int CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int LIN_W  = CITY_W + CNT_W + 1;
  localparam int TW     = mcts_pkg::TOUR_W;

  // load position and store
  logic [mcts_pkg::ADDR_W-1:0] load_pos_q;
  logic [mcts_pkg::ADDR_W-1:0] raddr;
  logic [EDGE_W-1:0]           rdata;

  // search state
  logic [CITY_W-1:0]     path_q [MAX_CITIES];
  logic [CNT_W-1:0]      next_q [MAX_CITIES];
  logic [TW-1:0]         part_q [MAX_CITIES];
  logic [CITY_W-1:0]     sp_q;
  logic [CITY_W-1:0]     start_q;
  logic [CITY_W-1:0]     try_col_q;
  logic [MAX_CITIES-1:0] visited_q;
  logic [TW-1:0]         best_cost_q;
  logic                  best_valid_q;

  logic [CNT_W-1:0]      n_eff;
  logic [CITY_W-1:0]     cur;
  logic [CNT_W-1:0]      nt;
  logic [TW-1:0]         part;
  logic [CITY_W-1:0]     sp_inc;
  logic [CITY_W-1:0]     col;
  logic [LIN_W-1:0]      lin;
  logic [TW:0]           sum;
  logic [TW-1:0]         cand;
  logic                  e_nz;
  logic                  advance;
  logic                  pop;
  logic                  push;
  logic                  better;

  mcts_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (mcts_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (load_pos_q),
    .wdata_i (edge_cost_i[EDGE_W-1:0]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // effective city count: zero reads as one, large values clamp
  always_comb begin
    if (city_count_i == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(city_count_i) > MAX_CITIES) begin
      n_eff = CNT_W'(MAX_CITIES);
    end else begin
      n_eff = city_count_i[CNT_W-1:0];
    end
  end

  // top of stack
  assign cur    = path_q[sp_q];
  assign nt     = next_q[sp_q];
  assign part   = part_q[sp_q];
  assign sp_inc = sp_q + CITY_W'(1);

  // status
  assign stat_o.close_now  = (CNT_W'(sp_q) + CNT_W'(1)) == n_eff;
  assign stat_o.exhausted  = (nt >= n_eff);
  assign stat_o.at_root    = (sp_q == '0);
  assign stat_o.last_start = (CNT_W'(start_q) == (n_eff - CNT_W'(1)));
  assign stat_o.skip_start = best_valid_q && (best_cost_q == '0);

  // store read address: row of the current city, column of candidate or start
  assign col   = stat_o.close_now ? start_q : nt[CITY_W-1:0];
  assign lin   = LIN_W'(cur) * LIN_W'(n_eff) + LIN_W'(col);
  assign raddr = mcts_pkg::ADDR_W'(lin);

  // saturating path cost with the edge just read
  assign sum  = {1'b0, part} + (TW + 1)'(rdata);
  assign cand = sum[TW] ? mcts_pkg::TOUR_MAX : sum[TW-1:0];
  assign e_nz = (rdata != '0);

  // search decisions
  assign advance = cmd_i.step && !stat_o.close_now && !stat_o.exhausted;
  assign pop     = (cmd_i.step && !stat_o.close_now && stat_o.exhausted) || cmd_i.close;
  assign push    = cmd_i.try_edge && e_nz && !visited_q[try_col_q]
                   && !(best_valid_q && (cand >= best_cost_q));
  assign better  = cmd_i.close && e_nz && (!best_valid_q || (cand < best_cost_q));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q   <= '0;
      sp_q         <= '0;
      start_q      <= '0;
      try_col_q    <= '0;
      visited_q    <= '0;
      best_cost_q  <= mcts_pkg::TOUR_MAX;
      best_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        load_pos_q <= matrix_last_i ? '0 : load_pos_q + mcts_pkg::ADDR_W'(1);
      end
      if (cmd_i.init) begin
        best_cost_q  <= mcts_pkg::TOUR_MAX;
        best_valid_q <= 1'b0;
        start_q      <= '0;
        visited_q    <= '0;
      end else if (cmd_i.start) begin
        if (stat_o.skip_start) begin
          start_q <= start_q + CITY_W'(1);
        end else begin
          visited_q <= MAX_CITIES'(1) << start_q;
          sp_q      <= '0;
        end
      end
      if (advance) begin
        try_col_q <= nt[CITY_W-1:0];
      end
      if (better) begin
        best_cost_q  <= cand;
        best_valid_q <= 1'b1;
      end
      if (pop) begin
        visited_q <= visited_q & ~(MAX_CITIES'(1) << cur);
        if (stat_o.at_root) begin
          start_q <= start_q + CITY_W'(1);
        end else begin
          sp_q <= sp_q - CITY_W'(1);
        end
      end else if (push) begin
        visited_q <= visited_q | (MAX_CITIES'(1) << try_col_q);
        sp_q      <= sp_inc;
      end
    end
  end

  // path stacks
  always_ff @(posedge clk_i) begin
    if (cmd_i.start && !stat_o.skip_start) begin
      path_q[0] <= start_q;
      next_q[0] <= '0;
      part_q[0] <= '0;
    end
    if (advance) begin
      next_q[sp_q] <= nt + CNT_W'(1);
    end
    if (push) begin
      path_q[sp_inc] <= try_col_q;
      next_q[sp_inc] <= '0;
      part_q[sp_inc] <= cand;
    end
  end

  // result fields
  assign tour_cost_o  = best_valid_q ? best_cost_q : '0;
  assign tour_found_o = best_valid_q;

endmodule

// File: dv/min_cost_tour_search_tb.sv
// testbench for min_cost_tour_search: matrix loads, tour prediction and result checks
`timescale 1ns / 100ps

// predicts the minimum tour of each loaded matrix and checks the result beats
class tour_scoreboard;
  typedef struct {
    logic [mcts_pkg::TOUR_W-1:0] cost;
    logic                        found;
  } tour_t;

  logic [mcts_pkg::EDGE_IN_W-1:0] cost_mem [mcts_pkg::STORE_DEPTH];
  bit                             written [mcts_pkg::STORE_DEPTH];
  logic [mcts_pkg::ADDR_W-1:0]    load_pos;
  logic [mcts_pkg::CFG_W-1:0]     city_reg;
  tour_t                          tour_q [$];
  logic [mcts_pkg::TOUR_W-1:0]    best;
  bit                             best_ok;
  int errors;
  int matrices;
  int results;
  int found_count;
  int widest;

  function new();
    city_reg = mcts_pkg::CITY_COUNT_RESET;
    load_pos = '0;
  endfunction

  function void write_city_count(logic [mcts_pkg::CFG_W-1:0] value);
    city_reg = value;
  endfunction

  // register value clamped to the usable range
  function int cities();
    if (city_reg == 0) return 1;
    if (city_reg > 16) return 16;
    return city_reg;
  endfunction

  // true when every store entry in [lo, hi) has been loaded since reset
  function bit stored(int lo, int hi);
    for (int k = lo; k < hi; k++) begin
      if (!written[k]) return 0;
    end
    return 1;
  endfunction

  function logic [mcts_pkg::TOUR_W-1:0] sat_add(logic [mcts_pkg::TOUR_W-1:0] a,
                                               logic [mcts_pkg::EDGE_IN_W-1:0] b);
    logic [mcts_pkg::TOUR_W:0] sum;
    sum = a + b;
    return (sum > mcts_pkg::TOUR_MAX) ? mcts_pkg::TOUR_MAX : sum[mcts_pkg::TOUR_W-1:0];
  endfunction

  function logic [mcts_pkg::EDGE_IN_W-1:0] cost_at(int n, int r, int c);
    return cost_mem[(r * n + c) & (mcts_pkg::STORE_DEPTH - 1)];
  endfunction

  // depth-first extension of a partial path, pruned against the best tour
  function void walk(int n, int origin, int cur, int depth,
                     logic [mcts_pkg::TOUR_W-1:0] partial, logic [15:0] seen);
    logic [mcts_pkg::EDGE_IN_W-1:0] e;
    logic [mcts_pkg::TOUR_W-1:0]    c;
    if (depth == n - 1) begin
      e = cost_at(n, cur, origin);
      if (e != 0) begin
        c = sat_add(partial, e);
        if (!best_ok || c < best) begin
          best    = c;
          best_ok = 1;
        end
      end
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (seen[i]) continue;
      e = cost_at(n, cur, i);
      if (e == 0) continue;
      c = sat_add(partial, e);
      if (best_ok && c >= best) continue;
      walk(n, origin, i, depth + 1, c, seen | (16'd1 << i));
    end
  endfunction

  // store one accepted matrix beat; the last one yields an expected tour
  function void note_beat(logic [mcts_pkg::EDGE_IN_W-1:0] cost, logic last);
    tour_t t;
    int    n;
    cost_mem[load_pos] = cost;
    written[load_pos]  = 1;
    load_pos++;
    if (!last) return;
    n       = cities();
    best    = mcts_pkg::TOUR_MAX;
    best_ok = 0;
    for (int s = 0; s < n; s++) begin
      walk(n, s, s, 0, '0, 16'd1 << s);
    end
    t.cost  = best_ok ? best : '0;
    t.found = best_ok;
    tour_q.push_back(t);
    load_pos = '0;
    matrices++;
    if (best_ok) found_count++;
    if (n > widest) widest = n;
  endfunction

  // compare one result beat with the oldest expected tour
  function void check_result(logic [mcts_pkg::TOUR_W-1:0] cost, logic found);
    tour_t t;
    results++;
    if (tour_q.size() == 0) begin
      $error("unexpected result beat: tour_cost %0d tour_found %0b", cost, found);
      errors++;
      return;
    end
    t = tour_q.pop_front();
    if (found !== t.found) begin
      $error("tour_found mismatch: expected %0b, actual %0b", t.found, found);
      errors++;
    end
    if (cost !== t.cost) begin
      $error("tour_cost mismatch: expected %0d, actual %0d", t.cost, cost);
      errors++;
    end
  endfunction
endclass

module min_cost_tour_search_tb;
  localparam logic [2:0] CITY_COUNT_ADDR = 3'd0;
  localparam int         DENSE_MAX       = 6;
  localparam int         QUIET_LIMIT     = 200000;
  localparam int         SETTLE          = 8;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [mcts_pkg::EDGE_IN_W-1:0] edge_cost_i;
  logic                           matrix_last_i;
  logic                           done_o;
  logic [mcts_pkg::TOUR_W-1:0]    tour_cost_o;
  logic                           tour_found_o;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [2:0]                     paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  tour_scoreboard                 sb;
  logic [mcts_pkg::EDGE_IN_W-1:0] mat_q [$];
  bit                             steady;
  int                             beats_sent;
  int                             cfg_writes;
  int                             quiet_cycles;

  min_cost_tour_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .edge_cost_i   (edge_cost_i),
    .matrix_last_i (matrix_last_i),
    .done_o        (done_o),
    .tour_cost_o   (tour_cost_o),
    .tour_found_o  (tour_found_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      sb.check_result(tour_cost_o, tour_found_o);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mostly small nonzero costs, with the extremes and full-width values mixed in
  function automatic logic [mcts_pkg::EDGE_IN_W-1:0] rand_cost();
    case ($urandom_range(0, 9))
      0:       return 20'd1;
      1:       return 20'hFFFFF;
      2, 3:    return $urandom_range(1, 20'hFFFFF);
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  // dense random matrix for few cities, a ring with a few extra edges for many
  function automatic void fill_matrix(int n);
    int density;
    int a;
    int b;
    mat_q.delete();
    if (n <= DENSE_MAX) begin
      case ($urandom_range(0, 3))
        0:       density = 0;
        1:       density = 25;
        2:       density = 55;
        default: density = 85;
      endcase
      repeat (n * n) mat_q.push_back(($urandom_range(0, 99) < density) ? '0 : rand_cost());
    end else begin
      repeat (n * n) mat_q.push_back('0);
      for (int r = 0; r < n; r++) mat_q[r * n + (r + 1) % n] = rand_cost();
      repeat ($urandom_range(0, 3)) begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        mat_q[a * n + b] = rand_cost();
      end
      // occasionally break the ring so no tour may exist
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, n - 1);
        mat_q[a * n + (a + 1) % n] = '0;
      end
    end
  endfunction

  // one input beat, held until accepted, then maybe a one-cycle gap
  task automatic send_beat(input logic [mcts_pkg::EDGE_IN_W-1:0] cost, input logic last);
    start         <= 1'b1;
    edge_cost_i   <= cost;
    matrix_last_i <= last;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_beat(cost, last);
    beats_sent++;
    if (!steady && $urandom_range(0, 99) < 41) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // send len beats from mat_q, padding with zero costs, last on the final beat
  task automatic send_matrix(input int len);
    for (int k = 0; k < len; k++) begin
      send_beat((k < mat_q.size()) ? mat_q[k] : '0, k == len - 1);
    end
  endtask

  // stop sending and wait for every outstanding tour
  task automatic drain();
    start <= 1'b0;
    while (sb.tour_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // apb write of city_count, then read it back
  task automatic set_city_count(input logic [mcts_pkg::CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CITY_COUNT_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.write_city_count(value);
    cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    // read back
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[mcts_pkg::CFG_W-1:0] !== value) begin
      $error("city_count mismatch: expected %0d, actual %0d",
             value, prdata[mcts_pkg::CFG_W-1:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int value;
    int n;
    int len;
    int pick;
    int phase;
    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    edge_cost_i   = '0;
    matrix_last_i = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    steady        = 0;
    beats_sent    = 0;
    cfg_writes    = 0;
    quiet_cycles  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // four cities at reset: ring of maximum costs plus one cheap chord
    mat_q.delete();
    for (int k = 0; k < 16; k++) begin
      mat_q.push_back((k % 4 == (k / 4 + 1) % 4) ? 20'hFFFFF : ((k == 2) ? 20'd1 : 20'd0));
    end
    send_matrix(16);
    drain();

    // zero city count acts as one city: self edge absent, then present
    set_city_count(5'd0);
    send_beat(20'd0, 1'b1);
    send_beat(20'd5, 1'b1);
    drain();

    // two cities: no edges, all maximum edges, then a short load over old entries
    set_city_count(5'd2);
    mat_q.delete();
    repeat (4) mat_q.push_back(20'd0);
    send_matrix(4);
    mat_q.delete();
    repeat (4) mat_q.push_back(20'hFFFFF);
    send_matrix(4);
    send_beat(20'd3, 1'b1);

    // random phases, each with its own city count
    phase = 0;
    while (beats_sent < 500) begin
      drain();
      case (phase)
        0:       value = 31;
        1:       value = 0;
        2:       value = 16;
        3:       value = 1;
        default: value = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                     : $urandom_range(0, DENSE_MAX);
      endcase
      steady = (phase >= 2 && phase < 5);
      set_city_count(5'(value));
      n = sb.cities();
      repeat ((n > DENSE_MAX) ? 1 : $urandom_range(1, 4)) begin
        fill_matrix(n);
        len  = n * n;
        pick = $urandom_range(0, 19);
        if ((n >= 13 || pick == 0) && n > 1) begin
          value = $urandom_range(1, n * n - 1);
          if (sb.stored(value, n * n)) len = value;
        end else if (pick == 1) begin
          len = n * n + $urandom_range(1, 8);
        end else if (pick == 2 && $urandom_range(0, 3) == 0) begin
          // overlong load that wraps the store position
          len = mcts_pkg::STORE_DEPTH + $urandom_range(1, 4);
        end
        send_matrix(len);
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.tour_q.size() != 0) begin
      $error("%0d expected tours never arrived", sb.tour_q.size());
      sb.errors++;
    end
    $display("covered %0d matrices (%0d with a tour, %0d without) in %0d beats",
             sb.matrices, sb.found_count, sb.matrices - sb.found_count, beats_sent);
    $display("%0d city_count writes, widest search %0d cities, %0d result beats checked",
             cfg_writes, sb.widest, sb.results);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: min_cost_tour_search.f
hdl/mcts_pkg.sv
hdl/mcts_ram.sv
hdl/mcts_ctrl.sv
hdl/mcts_dp.sv
hdl/min_cost_tour_search.sv
dv/min_cost_tour_search_tb.sv
